>>> src/plst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types for the positional list store: operation and status codes,
// the command passed down the row of storage cells, and controller states.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } plst_op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOB  = 2'd1,
    STAT_FULL = 2'd2
  } plst_status_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_WRITE
  } plst_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } plst_state_e;

  typedef struct packed {
    plst_cmd_e          cmd;
    logic [WordW-1:0]   wdata;
  } plst_cell_ctl_t;

endpackage

`default_nettype wire

>>> src/plst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plst_cell
// One list entry. Shifts from its lower or upper neighbor, or takes the
// write word, and presents its word when its index is selected.
// ----------------------------------------------------------------------------
module plst_cell import plst_pkg::*; #(
  parameter int unsigned IW  = 8,
  parameter int unsigned IDX = 0
) (
  input  wire logic             clk_i,
  input  wire plst_cell_ctl_t   ctl_i,
  input  wire logic [IW-1:0]    idx_i,
  input  wire logic [WordW-1:0] lower_i,
  input  wire logic [WordW-1:0] upper_i,
  output logic [WordW-1:0]      data_o,
  output logic [WordW-1:0]      match_o
);

  logic [WordW-1:0] data_q;
  logic [WordW-1:0] data_d;
  logic             hit;
  logic             above;

  assign hit   = (idx_i == IW'(IDX));
  assign above = (IW'(IDX) > idx_i);

  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (hit) begin
          data_d = ctl_i.wdata;
        end else if (above) begin
          data_d = lower_i;
        end
      end
      CMD_REMOVE: begin
        if (hit || above) begin
          data_d = upper_i;
        end
      end
      CMD_WRITE: begin
        if (hit) begin
          data_d = ctl_i.wdata;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = hit ? data_q : '0;

endmodule

`default_nettype wire

>>> src/plst_or_tree.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plst_or_tree
// Registered binary OR tree that collects the one selected cell word.
// ----------------------------------------------------------------------------
module plst_or_tree import plst_pkg::*; #(
  parameter int unsigned LEAVES = 256
) (
  input  wire logic             clk_i,
  input  wire logic [WordW-1:0] leaf_i [LEAVES],
  output logic [WordW-1:0]      root_o
);

  localparam int unsigned Lvl = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned P   = 1 << Lvl;

  logic [WordW-1:0] node_q [1:2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < LEAVES) begin : g_used
      always_ff @(posedge clk_i) begin
        node_q[P+j] <= leaf_i[j];
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[P+j] <= '0;
      end
    end
  end

  for (genvar n = 1; n < P; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[n] <= node_q[2*n] | node_q[2*n+1];
    end
  end

  assign root_o = node_q[1];

endmodule

`default_nettype wire

>>> src/positional_list_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH 32-bit words with insert, remove, get and set
// at a position; negative positions count from the end of the list.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. Insert, set and any rejected
// operation go from IDLE straight to DONE, where the result is registered.
// Remove and get pass through READ first: the selected entry is collected
// through a registered OR tree over the row of cells, one tree level per
// cycle. Inserts and removes shift all later cells by one at once. The next
// transaction is accepted while a result still waits in the output register.
module positional_list_store import plst_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [9:0]  position_i,
  input  wire logic [31:0] value_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      value_out_o,
  output logic [1:0]       status_o,
  output logic [8:0]       length_out_o
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = ((CW > 10) ? CW : 10) + 2;
  localparam int unsigned Lvl  = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(Lvl + 1) + 1;

  plst_state_e       state_q, state_d;
  plst_op_e          op_q;
  plst_status_e      stat_q;
  logic [IW-1:0]     idx_q;
  logic [WordW-1:0]  val_q;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_value_q, out_value_d;
  plst_status_e      out_stat_q, out_stat_d;

  logic              in_fire;
  logic              commit;
  plst_op_e          op_in;
  logic signed [SW-1:0] pos_s, len_s, idx_s;
  plst_status_e      stat_in;
  plst_cell_ctl_t    ctl;
  logic [WordW-1:0]  cell_data  [DEPTH];
  logic [WordW-1:0]  cell_match [DEPTH];
  logic [WordW-1:0]  root;

  assign op_in   = plst_op_e'(op_i);
  assign pos_s   = {{(SW-10){position_i[9]}}, position_i};
  assign len_s   = {{(SW-CW){1'b0}}, count_q};

  always_comb begin
    stat_in = STAT_OK;
    if (op_in == OP_INSERT) begin
      idx_s = position_i[9] ? (len_s + pos_s + SW'(1)) : pos_s;
      if (idx_s < 0 || idx_s > len_s) begin
        stat_in = STAT_OOB;
      end else if (count_q == CW'(DEPTH)) begin
        stat_in = STAT_FULL;
      end
    end else begin
      idx_s = position_i[9] ? (len_s + pos_s) : pos_s;
      if (idx_s < 0 || idx_s >= len_s) begin
        stat_in = STAT_OOB;
      end
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    commit      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_stat_d  = out_stat_q;
    ctl.cmd     = CMD_HOLD;
    ctl.wdata   = val_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          if (stat_in == STAT_OK && (op_in == OP_REMOVE || op_in == OP_GET)) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(Lvl)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          commit      = 1'b1;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_value_d = '0;
          if (stat_q == STAT_OK) begin
            case (op_q)
              OP_INSERT: begin
                ctl.cmd = CMD_INSERT;
                count_d = count_q + CW'(1);
              end
              OP_REMOVE: begin
                ctl.cmd     = CMD_REMOVE;
                count_d     = count_q - CW'(1);
                out_value_d = root;
              end
              OP_GET: begin
                out_value_d = root;
              end
              OP_SET: begin
                ctl.cmd = CMD_WRITE;
              end
              default: begin
                ctl.cmd = CMD_HOLD;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_in;
      stat_q <= stat_in;
      idx_q  <= idx_s[IW-1:0];
      val_q  <= value_in_i;
    end
    out_value_q <= out_value_d;
    out_stat_q  <= out_stat_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] lower;
    logic [WordW-1:0] upper;
    if (i == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi0
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end
    plst_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (idx_q),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );
  end

  plst_or_tree #(
    .LEAVES (DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_match),
    .root_o (root)
  );

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = out_value_q;
  assign status_o     = out_stat_q;
  assign length_out_o = 9'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q == STAT_FULL) |-> (count_q == CW'(DEPTH)))
    else $error("full status with list not full");

  a_read_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (stat_q == STAT_OK && (op_q == OP_REMOVE || op_q == OP_GET)))
    else $error("tree read for an operation that needs none");

  a_commit_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed transaction without result");

endmodule

`default_nettype wire
